// ----- hdl/chr_pkg.sv -----
// package for the consistent hash ring: sizes, request/result structs,
// controller-datapath command and status types; no dependencies
package chr_pkg;

    localparam int POINTS    = 2048;
    localparam int SERVERS   = 32;
    localparam int IDX_W     = $clog2(POINTS);
    localparam int CNT_W     = $clog2(POINTS + 1);
    localparam int SRV_W     = 5;
    localparam int SRV_IDX_W = $clog2(SERVERS);
    localparam int HASH_W    = 32;
    localparam int HIT_W     = 64;
    localparam int ENTRY_W   = HASH_W + SRV_W;

    localparam logic       REQ_INSERT   = 1'b0;
    localparam logic       REQ_LOOKUP   = 1'b1;
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [HASH_W-1:0] hash_value;
        logic [SRV_W-1:0]  server_id;
        logic              last_point;
    } chr_req_t;

    typedef struct packed {
        logic [SRV_W-1:0]  chosen_server;
        logic [HIT_W-1:0]  hit_total;
        logic [1:0]        status;
    } chr_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;     // capture request, start search window
        logic rd_mid;       // issue ram read at midpoint
        logic cmp_mid;      // narrow search window from read data
        logic rd_shift;     // read entry shift_idx-1
        logic wr_shift;     // write read data to shift_idx, decrement
        logic wr_new;       // write new entry at search position, bump count
        logic rd_pos;       // read entry at lookup position
        logic rd_hits;      // capture owner server id from read data
        logic wr_hits;      // increment counter, form result
        logic set_full;     // form full result
        logic set_empty;    // form empty result
        logic set_ok;       // form insert ok result
        logic publish;      // copy finished result to the output register
    } chr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_lookup;
        logic ring_full;
        logic ring_empty;
        logic search_done;
        logic shift_done;
    } chr_stat_t;

endpackage

// ----- hdl/chr_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module chr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/chr_datapath.sv -----
// datapath: ring memory, search window, shift index, hit counters, result
// depends on chr_pkg and chr_ram
module chr_datapath
    import chr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  chr_req_t  req,
    input  chr_cmd_t  cmd,
    output chr_stat_t stat,
    output chr_rsp_t  result
);

    logic [HASH_W-1:0]    key_reg;
    logic [SRV_W-1:0]     sid_reg;
    logic                 type_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     mid;
    logic [CNT_W-1:0]     shift_reg, shift_next;
    logic [SRV_W-1:0]     owner_reg;
    chr_rsp_t             result_reg, result_next;
    chr_rsp_t             out_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

    logic                 hit_we;
    logic [SRV_IDX_W-1:0] hit_addr;
    logic [HIT_W-1:0]     hit_wdata, hit_rdata;
    logic [SERVERS-1:0]   hit_valid_reg;
    logic [HIT_W-1:0]     hit_cur;
    logic [CNT_W-1:0]     pos_wrap;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign pos_wrap = (lo_reg >= count_reg) ? '0 : lo_reg;

    chr_ram #(.WIDTH(ENTRY_W), .DEPTH(POINTS)) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    chr_ram #(.WIDTH(HIT_W), .DEPTH(SERVERS)) u_hits (
        .clk   (clk),
        .we    (hit_we),
        .addr  (hit_addr),
        .wdata (hit_wdata),
        .rdata (hit_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
        ram_addr  = mid[IDX_W-1:0];
        if (cmd.rd_shift)
        begin
            ram_addr = IDX_W'(shift_reg - CNT_W'(1));
        end
        else if (cmd.wr_shift)
        begin
            ram_we   = 1'b1;
            ram_addr = shift_reg[IDX_W-1:0];
        end
        else if (cmd.wr_new)
        begin
            ram_we    = 1'b1;
            ram_addr  = lo_reg[IDX_W-1:0];
            ram_wdata = {key_reg, sid_reg};
        end
        else if (cmd.rd_pos)
        begin
            ram_addr = pos_wrap[IDX_W-1:0];
        end
    end

    // counters never written since reset read as zero
    assign hit_addr  = SRV_IDX_W'(owner_reg);
    assign hit_cur   = hit_valid_reg[hit_addr] ? hit_rdata : '0;
    assign hit_wdata = hit_cur + HIT_W'(1);
    assign hit_we    = cmd.wr_hits;

    always_comb
    begin
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        result_next = result_reg;
        if (cmd.load_req)
        begin
            lo_next    = '0;
            hi_next    = count_reg;
            shift_next = count_reg;
        end
        if (cmd.cmp_mid)
        begin
            if (ram_rdata[ENTRY_W-1:SRV_W] <= key_reg)
            begin
                lo_next = mid + CNT_W'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.wr_shift)
        begin
            shift_next = shift_reg - CNT_W'(1);
        end
        if (cmd.wr_new)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.wr_hits)
        begin
            result_next = '{chosen_server: owner_reg, hit_total: hit_wdata, status: STAT_OK};
        end
        if (cmd.set_full)
        begin
            result_next = '{chosen_server: '0, hit_total: '0, status: STAT_FULL};
        end
        if (cmd.set_empty)
        begin
            result_next = '{chosen_server: '0, hit_total: '0, status: STAT_EMPTY};
        end
        if (cmd.set_ok)
        begin
            result_next = '{chosen_server: '0, hit_total: '0, status: STAT_OK};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            hit_valid_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (hit_we)
            begin
                hit_valid_reg[hit_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        shift_reg  <= shift_next;
        result_reg <= result_next;
        // the published result holds while the receiver stalls
        if (cmd.publish)
        begin
            out_reg <= result_reg;
        end
        if (cmd.load_req)
        begin
            key_reg  <= req.hash_value;
            sid_reg  <= req.server_id;
            type_reg <= req.req_type;
        end
        if (cmd.rd_hits)
        begin
            owner_reg <= ram_rdata[SRV_W-1:0];
        end
    end

    assign stat.is_lookup   = (type_reg == REQ_LOOKUP);
    assign stat.ring_full   = (count_reg == CNT_W'(POINTS));
    assign stat.ring_empty  = (count_reg == '0);
    assign stat.search_done = (lo_reg >= hi_reg);
    assign stat.shift_done  = (shift_reg <= lo_reg);
    assign result           = out_reg;

endmodule

// ----- hdl/chr_ctrl.sv -----
// controller state machine: sequences search, shift and counter update
// depends on chr_pkg
module chr_ctrl
    import chr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  chr_stat_t stat,
    output chr_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_SRCH_RD, ST_SRCH_CMP, ST_SHIFT_RD, ST_SHIFT_WR,
        ST_INSERT, ST_POS_RD, ST_OWNER, ST_HIT_RD, ST_HIT_WR, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.is_lookup && stat.ring_empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (!stat.is_lookup && stat.ring_full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                if (stat.search_done)
                begin
                    state_next = stat.is_lookup ? ST_POS_RD : ST_SHIFT_RD;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                cmd.cmp_mid = 1'b1;
                state_next  = ST_SRCH_RD;
            end
            ST_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_INSERT:
            begin
                cmd.wr_new = 1'b1;
                cmd.set_ok = 1'b1;
                state_next = ST_DONE;
            end
            ST_POS_RD:
            begin
                cmd.rd_pos = 1'b1;
                state_next = ST_OWNER;
            end
            ST_OWNER:
            begin
                cmd.rd_hits = 1'b1;
                state_next  = ST_HIT_RD;
            end
            ST_HIT_RD:
            begin
                state_next = ST_HIT_WR;
            end
            ST_HIT_WR:
            begin
                cmd.wr_hits = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/consistent_hash_ring_top.sv -----
// consistent hash ring top level: controller plus datapath
// depends on chr_pkg, chr_ctrl, chr_datapath
//
// usage:
//   request channel in_valid / in_stall / in_data carries insert and lookup
//   requests; result channel out_valid / out_stall / out_data returns one
//   result per request, in order.
//   an insert binary-searches the sorted ring (a read and a compare per
//   probe), then moves the tail up one entry at a time (a read and a write
//   per moved entry) and writes the new point. a lookup binary-searches,
//   reads the entry at the found position and bumps that server's hit
//   counter. the ring holds up to 2048 points in one single-port memory.
//   full-ring inserts and empty-ring lookups finish without a search.
//   one request is in work at a time; the finished result sits in an output
//   register, so the next request is taken while the result waits. a stalled
//   receiver holds the result and the block waits before publishing the next.
//   reset empties the ring and zeroes all hit counters at once; no clearing
//   pass is needed.
module consistent_hash_ring_top
    import chr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  chr_req_t in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output chr_rsp_t out_data
);

    chr_cmd_t  cmd;
    chr_stat_t stat;

    chr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    chr_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (in_data),
        .cmd    (cmd),
        .stat   (stat),
        .result (out_data)
    );

endmodule
